[rtl/knn_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package knn_pkg;
  localparam int unsigned CFG_W = 11;
  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_FEATS = 2'd1;
  localparam logic [1:0] REG_K = 2'd2;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;
endpackage
`default_nettype wire

[rtl/knn_dist.sv]
`timescale 1ns / 1ps
`default_nettype none
module knn_dist #(
  parameter int unsigned DW = 40
) (
  input  wire logic          clk,
  input  wire logic          clr,
  input  wire logic          acc_en,
  input  wire logic [15:0]   qv,
  input  wire logic [15:0]   tv,
  output logic [DW-1:0]      sum
);
  logic [16:0] diff_r;
  logic        sq_vld_r;
  logic [DW-1:0] sum_r;
  logic signed [16:0] d;
  logic [33:0] sq;
  assign d = $signed({qv[15], qv}) - $signed({tv[15], tv});
  assign sq = 34'(diff_r) * 34'(diff_r);
  always_ff @(posedge clk) begin
    diff_r <= d[16] ? 17'(-d) : 17'(d);
    sq_vld_r <= acc_en;
    if (clr) begin
      sum_r <= '0;
    end else if (sq_vld_r) begin
      sum_r <= sum_r + DW'(sq);
    end
  end
  assign sum = sum_r;
endmodule
`default_nettype wire

[rtl/knn_binary_classifier.sv]
// Channel  Ports                                       Transfer
// in       start, busy, in_cmd/row_index/feature_*     start & !busy
// out      out_valid, out_predicted_positive, votes    out_valid, one cycle
// cfg      cfg_we, cfg_index, cfg_data                 cfg_we
// Loads and non-final query elements are stored without raising busy. The final query
// element starts a search: per row, one subtract/square/accumulate unit is fed from the
// training memory one element a cycle, then the distance is inserted into the sorted
// neighbour list; then the k neighbours vote and the result is registered. With no rows
// or k = 0 the search goes straight to the result. busy is high throughout.
// Reset is synchronous; memories are not cleared. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module knn_binary_classifier #(
  parameter int unsigned MAX_TRAIN = 1024,
  parameter int unsigned MAX_FEATURES = 16,
  parameter int unsigned MAX_K = 31
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_cmd,
  input  wire logic [9:0]  in_row_index,
  input  wire logic [3:0]  in_feature_index,
  input  wire logic signed [15:0] in_feature_value,
  input  wire logic        in_label_positive,
  output logic             out_valid,
  output logic             out_predicted_positive,
  output logic [4:0]       out_positive_votes,
  output logic [4:0]       out_negative_votes,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [knn_pkg::CFG_W-1:0] cfg_data
);
  localparam int unsigned RW = (MAX_TRAIN > 1) ? $clog2(MAX_TRAIN) : 1;
  localparam int unsigned FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int unsigned AW = (MAX_TRAIN * MAX_FEATURES > 1) ?
                               $clog2(MAX_TRAIN * MAX_FEATURES) : 1;
  localparam int unsigned KW = $clog2(MAX_K + 1);
  localparam int unsigned DW = 34 + FW + 1;
  localparam int unsigned NW = $clog2(MAX_TRAIN + 1);
  localparam int unsigned NFW = $clog2(MAX_FEATURES + 1);

  typedef enum logic [2:0] {S_IDLE, S_FEAT, S_DRAIN, S_SCAN, S_VOTE, S_OUT} state_t;
  state_t state_r;

  logic [15:0] tmem [MAX_TRAIN*MAX_FEATURES];
  logic        lmem [MAX_TRAIN];
  logic [15:0] qmem [MAX_FEATURES];
  logic [DW-1:0] bd_r [MAX_K];
  logic          bl_r [MAX_K];
  logic [MAX_K-1:0] bv_r;

  logic [10:0] rows_cfg_r;
  logic [4:0]  feat_cfg_r, k_cfg_r;
  logic [NW-1:0] nrows_r, row_r;
  logic [NFW-1:0] nf_r;
  logic [FW:0]   f_r;
  logic [KW-1:0] k_r, idx_r;
  logic [15:0]   tv_r, qv_r;
  logic          lab_r, lrd_r, shift_r;
  logic [1:0]    drain_r;
  logic [DW-1:0] dist_sum, d_r;
  logic [4:0]    pos_r, neg_r;
  logic          acc_en_r, clr_r;
  logic [NW-1:0] rows_c;
  logic [NFW-1:0] nf_c;
  logic [KW-1:0] k_c;
  logic [FW-1:0] fi;
  logic          fi_ok, row_ok;

  always_comb begin
    rows_c = (32'(rows_cfg_r) > MAX_TRAIN) ? NW'(MAX_TRAIN) : NW'(rows_cfg_r);
    nf_c = (32'(feat_cfg_r) > MAX_FEATURES) ? NFW'(MAX_FEATURES) : NFW'(feat_cfg_r);
    if (nf_c == '0) nf_c = NFW'(1);
    k_c = (32'(k_cfg_r) > MAX_K) ? KW'(MAX_K) : KW'(k_cfg_r);
    if (32'(k_c) > 32'(rows_c)) k_c = KW'(rows_c);
    fi = FW'(in_feature_index);
    fi_ok = 32'(in_feature_index) < MAX_FEATURES;
    row_ok = 32'(in_row_index) < MAX_TRAIN;
  end

  knn_dist #(.DW(DW)) u_dist (
    .clk(clk), .clr(clr_r), .acc_en(acc_en_r), .qv(qv_r), .tv(tv_r), .sum(dist_sum)
  );

  always_ff @(posedge clk) begin
    if (start && !busy && in_cmd == knn_pkg::CMD_LOAD && row_ok && fi_ok) begin
      tmem[AW'(32'(in_row_index) * MAX_FEATURES + 32'(fi))] <= in_feature_value;
      lmem[RW'(in_row_index)] <= in_label_positive;
    end
    if (start && !busy && in_cmd == knn_pkg::CMD_QUERY && fi_ok) begin
      qmem[fi] <= in_feature_value;
    end
    tv_r <= tmem[AW'(32'(row_r) * MAX_FEATURES + 32'(FW'(f_r)))];
    qv_r <= qmem[FW'(f_r)];
    lrd_r <= lmem[RW'(row_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rows_cfg_r <= 11'd1;
      feat_cfg_r <= 5'd16;
      k_cfg_r <= 5'd1;
      out_valid <= 1'b0;
      acc_en_r <= 1'b0;
      clr_r <= 1'b0;
      bv_r <= '0;
    end else begin
      out_valid <= 1'b0;
      acc_en_r <= 1'b0;
      clr_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          knn_pkg::REG_ROWS:  rows_cfg_r <= cfg_data;
          knn_pkg::REG_FEATS: feat_cfg_r <= cfg_data[4:0];
          knn_pkg::REG_K:     k_cfg_r <= cfg_data[4:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (start && in_cmd == knn_pkg::CMD_QUERY &&
              32'(in_feature_index) == 32'(nf_c) - 1) begin
            nrows_r <= rows_c;
            nf_r <= nf_c;
            k_r <= k_c;
            row_r <= '0;
            f_r <= '0;
            bv_r <= '0;
            pos_r <= '0;
            neg_r <= '0;
            clr_r <= 1'b1;
            state_r <= (rows_c == '0 || k_c == '0) ? S_OUT : S_FEAT;
          end
        end
        S_FEAT: begin
          acc_en_r <= 1'b1;
          if (32'(f_r) == 32'(nf_r) - 1) begin
            drain_r <= '0;
            state_r <= S_DRAIN;
          end else begin
            f_r <= f_r + 1'b1;
          end
        end
        S_DRAIN: begin
          drain_r <= drain_r + 2'd1;
          if (drain_r == 2'd2) begin
            d_r <= dist_sum;
            lab_r <= lrd_r;
            shift_r <= 1'b0;
            idx_r <= '0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // insert: walk slots, once placed the displaced entry moves down one slot a cycle
          if (idx_r == KW'(MAX_K)) begin
            if (32'(row_r) + 1 == 32'(nrows_r)) begin
              idx_r <= '0;
              state_r <= S_VOTE;
            end else begin
              row_r <= row_r + 1'b1;
              f_r <= '0;
              clr_r <= 1'b1;
              state_r <= S_FEAT;
            end
          end else if (shift_r || !bv_r[idx_r] || d_r < bd_r[idx_r]) begin
            bd_r[idx_r] <= d_r;
            bl_r[idx_r] <= lab_r;
            bv_r[idx_r] <= 1'b1;
            if (bv_r[idx_r] && 32'(idx_r) + 1 < 32'(k_r)) begin
              d_r <= bd_r[idx_r];
              lab_r <= bl_r[idx_r];
              shift_r <= 1'b1;
              idx_r <= idx_r + 1'b1;
            end else begin
              idx_r <= KW'(MAX_K);
            end
          end else if (32'(idx_r) + 1 < 32'(k_r)) begin
            idx_r <= idx_r + 1'b1;
          end else begin
            idx_r <= KW'(MAX_K);
          end
        end
        S_VOTE: begin
          if (bl_r[idx_r]) pos_r <= pos_r + 5'd1;
          else neg_r <= neg_r + 5'd1;
          if (32'(idx_r) + 1 == 32'(k_r)) state_r <= S_OUT;
          else idx_r <= idx_r + 1'b1;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          out_predicted_positive <= !(neg_r > pos_r);
          out_positive_votes <= pos_r;
          out_negative_votes <= neg_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);

  a_one_shot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result");
  a_vote_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_positive_votes) + 32'(out_negative_votes) <= MAX_K)
    else $error("vote count");
  a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy at result");
endmodule
`default_nettype wire

[tb/tb_knn_binary_classifier.sv]
`timescale 1ns / 1ps
module tb_knn_binary_classifier;

  localparam int NROWS = 1024;
  localparam int NFEAT = 16;
  localparam int NK = 31;
  localparam int CW = knn_pkg::CFG_W;
  localparam longint LIMIT = 1500000;

  typedef struct packed {
    logic       predicted_positive;
    logic [4:0] positive_votes;
    logic [4:0] negative_votes;
  } vote_t;

  class vote_scoreboard;
    logic signed [15:0] feat[NROWS][NFEAT];
    logic lbl[NROWS];
    logic signed [15:0] qv[NFEAT];
    int unsigned rows_reg = 1, feats_reg = 16, k_reg = 1;
    vote_t votes_due[$];
    int errors = 0;

    function void set_reg(logic [1:0] idx, logic [CW-1:0] v);
      case (idx)
        knn_pkg::REG_ROWS:  rows_reg = v;
        knn_pkg::REG_FEATS: feats_reg = v[4:0];
        knn_pkg::REG_K:     k_reg = v[4:0];
        default: ;
      endcase
    endfunction

    function void note(logic c, logic [9:0] row, logic [3:0] fi, logic signed [15:0] v,
                       logic lab);
      int unsigned nf, nr, k, cnt, p, j, pos, neg;
      longint unsigned bd[NK];
      logic bl[NK];
      longint unsigned d;
      longint df;
      vote_t res;
      if (c == knn_pkg::CMD_LOAD) begin
        feat[row][fi] = v;
        lbl[row] = lab;
        return;
      end
      qv[fi] = v;
      nf = feats_reg > NFEAT ? NFEAT : feats_reg;
      if (nf == 0) nf = 1;
      if (fi != nf - 1) return;
      nr = rows_reg > NROWS ? NROWS : rows_reg;
      k = k_reg > NK ? NK : k_reg;
      if (k > nr) k = nr;
      cnt = 0;
      for (int r = 0; r < nr && k > 0; r++) begin
        d = 0;
        for (int f = 0; f < nf; f++) begin
          df = longint'(qv[f]) - longint'(feat[r][f]);
          d += df * df;
        end
        if (cnt == k && d >= bd[k-1]) continue;
        p = 0;
        while (p < cnt && bd[p] <= d) p++;
        j = (cnt < k) ? cnt : k - 1;
        while (j > p) begin
          bd[j] = bd[j-1];
          bl[j] = bl[j-1];
          j--;
        end
        bd[p] = d;
        bl[p] = lbl[r];
        if (cnt < k) cnt++;
      end
      pos = 0;
      neg = 0;
      for (int i = 0; i < cnt; i++)
        if (bl[i]) pos++;
        else neg++;
      res.predicted_positive = (neg > pos) ? 1'b0 : 1'b1;
      res.positive_votes = pos[4:0];
      res.negative_votes = neg[4:0];
      votes_due.insert(votes_due.size(), res);
    endfunction

    function void check(vote_t got);
      vote_t exp_v;
      if (votes_due.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp_v = votes_due.pop_front();
      if (got.predicted_positive !== exp_v.predicted_positive) begin
        $display("%0t: predicted_positive exp %0d got %0d", $time,
                 exp_v.predicted_positive, got.predicted_positive);
        errors++;
      end
      if (got.positive_votes !== exp_v.positive_votes) begin
        $display("%0t: positive_votes exp %0d got %0d", $time,
                 exp_v.positive_votes, got.positive_votes);
        errors++;
      end
      if (got.negative_votes !== exp_v.negative_votes) begin
        $display("%0t: negative_votes exp %0d got %0d", $time,
                 exp_v.negative_votes, got.negative_votes);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_cmd = 1'b0;
  logic [9:0] in_row_index = '0;
  logic [3:0] in_feature_index = '0;
  logic signed [15:0] in_feature_value = '0;
  logic in_label_positive = 1'b0;
  logic out_valid;
  logic out_predicted_positive;
  logic [4:0] out_positive_votes;
  logic [4:0] out_negative_votes;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;

  knn_binary_classifier DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_row_index(in_row_index), .in_feature_index(in_feature_index),
    .in_feature_value(in_feature_value), .in_label_positive(in_label_positive),
    .out_valid(out_valid), .out_predicted_positive(out_predicted_positive),
    .out_positive_votes(out_positive_votes), .out_negative_votes(out_negative_votes),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  vote_scoreboard sb = new();
  bit written[NROWS][NFEAT];
  bit quiet = 1'b0;
  int nf_now = 16;
  longint cycles = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("knn_binary_classifier: mismatch");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst_n && out_valid)
      sb.check({out_predicted_positive, out_positive_votes, out_negative_votes});
  end

  function automatic logic [15:0] pick_value();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'(($urandom_range(0, 8) - 4) * 64);
  endfunction

  task automatic send(logic c, logic [9:0] r, logic [3:0] f, logic [15:0] v, logic l);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= c;
    in_row_index <= r;
    in_feature_index <= f;
    in_feature_value <= v;
    in_label_positive <= l;
    do @(negedge clk); while (busy);
    @(posedge clk);
    sb.note(c, r, f, v, l);
    if (c == knn_pkg::CMD_LOAD) written[r][f] = 1'b1;
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (busy || sb.votes_due.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [CW-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic query_seq(int nf);
    for (int f = 0; f < nf; f++)
      send(knn_pkg::CMD_QUERY, 10'($urandom), 4'(f), pick_value(), 1'($urandom));
  endtask

  // reprogram while idle, then fill every element the new setting will read
  task automatic new_phase(int rows, int feats, int k);
    int nr;
    settle();
    cfg_write(knn_pkg::REG_ROWS, CW'(rows));
    cfg_write(knn_pkg::REG_FEATS, CW'(feats));
    cfg_write(knn_pkg::REG_K, CW'(k));
    nr = rows > NROWS ? NROWS : rows;
    if (k == 0) nr = 0;
    nf_now = feats > NFEAT ? NFEAT : (feats == 0 ? 1 : feats);
    for (int r = 0; r < nr; r++)
      for (int f = 0; f < nf_now; f++)
        if (!written[r][f])
          send(knn_pkg::CMD_LOAD, 10'(r), 4'(f), pick_value(), 1'($urandom));
  endtask

  task automatic random_items(int n);
    int f;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1: send(knn_pkg::CMD_LOAD,
                   10'($urandom_range(0, 1 + $urandom_range(0, 1) * 1022)),
                   4'($urandom), pick_value(), 1'($urandom));
        2: begin
          f = $urandom_range(0, 15);
          if (f == nf_now - 1) f = (f + 1) % 16;
          send(knn_pkg::CMD_QUERY, 10'($urandom), 4'(f), pick_value(), 1'($urandom));
        end
        default: query_seq(nf_now);
      endcase
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // many rows, one feature, many equal distances, widest k
    new_phase(32, 1, 31);
    send(knn_pkg::CMD_QUERY, 10'h3FF, 4'd0, 16'sh7FFF, 1'b1);
    send(knn_pkg::CMD_QUERY, 10'h000, 4'd0, 16'sh8000, 1'b0);
    send(knn_pkg::CMD_QUERY, 10'h155, 4'd0, 16'sh0000, 1'b1);
    send(knn_pkg::CMD_LOAD, 10'h3FF, 4'd15, 16'sh8000, 1'b1);
    send(knn_pkg::CMD_LOAD, 10'h000, 4'd0, 16'sh7FFF, 1'b0);
    send(knn_pkg::CMD_QUERY, 10'h2AA, 4'd0, 16'sh7FFF, 1'b0);

    // oversized rows register, zero features, zero k: nobody votes
    new_phase(2047, 0, 0);
    send(knn_pkg::CMD_QUERY, 10'h0, 4'd0, 16'sh0100, 1'b0);
    // no rows, oversized feature count
    new_phase(0, 31, 5);
    query_seq(16);
    // k above rows
    new_phase(6, 16, 31);
    query_seq(16);
    send(knn_pkg::CMD_QUERY, 10'h0, 4'd3, 16'sh1234, 1'b0);
    query_seq(16);
    new_phase(1, 16, 1);
    query_seq(16);

    for (int p = 0; p < 6; p++) begin
      new_phase($urandom_range(1, 12), $urandom_range(0, 17), $urandom_range(0, 31));
      random_items(6);
    end
    new_phase(3, 2, 2);
    random_items(20);
    quiet = 1'b1;
    new_phase(12, 4, 7);
    random_items(20);
    settle();

    if (sb.errors == 0 && sb.votes_due.size() == 0)
      $display("knn_binary_classifier: match");
    else
      $display("knn_binary_classifier: mismatch");
    $finish;
  end
endmodule

[filelist.f]
rtl/knn_pkg.sv
rtl/knn_dist.sv
rtl/knn_binary_classifier.sv
tb/tb_knn_binary_classifier.sv
